[design/stt_pkg.sv]
// ---------------------------------------------------------------------------
// stt_pkg - shared types and constants of the transposition table
// Field widths, bound-kind and function codes, table slot and command types.
// ---------------------------------------------------------------------------
package stt_pkg;

    // Default slot count of the table
    localparam int DEF_TABLE_ENTRIES = 4096;

    // Field widths
    localparam int KEY_W   = 64;
    localparam int KIND_W  = 2;
    localparam int DEPTH_W = 8;
    localparam int MOVE_W  = 32;
    localparam int SCORE_W = 32;
    localparam int USED_W  = 13;
    localparam int CNT_W   = 32;

    // Fill counter saturates here
    localparam logic [USED_W-1:0] USED_MAX = '1;

    // Depth of the command queue between front and back
    localparam int FIFO_DEPTH = 2;

    // Function codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_PROBE = 1'b1;

    // Bound kinds
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALPHA   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BETA    = 2'd3;

    // One table slot as kept in memory
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [KIND_W-1:0]         kind;
        logic [DEPTH_W-1:0]        depth;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
    } t_slot;

    // One accepted request transaction
    typedef struct packed {
        logic                      func;
        logic [KEY_W-1:0]          position_key;
        logic [KIND_W-1:0]         bound_kind;
        logic [DEPTH_W-1:0]        search_depth;
        logic [MOVE_W-1:0]         move_word;
        logic signed [SCORE_W-1:0] move_score;
        logic signed [SCORE_W-1:0] alpha_limit;
        logic signed [SCORE_W-1:0] beta_limit;
    } t_cmd;

endpackage

[design/stt_req_if.sv]
// ---------------------------------------------------------------------------
// stt_req_if - request channel of the transposition table
// Valid/ready channel carrying one store or probe transaction.
// ---------------------------------------------------------------------------
interface stt_req_if import stt_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [KEY_W-1:0]          position_key;
    logic [KIND_W-1:0]         bound_kind;
    logic [DEPTH_W-1:0]        search_depth;
    logic [MOVE_W-1:0]         move_word;
    logic signed [SCORE_W-1:0] move_score;
    logic signed [SCORE_W-1:0] alpha_limit;
    logic signed [SCORE_W-1:0] beta_limit;

    modport source (
        output valid, func, position_key, bound_kind, search_depth,
               move_word, move_score, alpha_limit, beta_limit,
        input  ready
    );

    modport sink (
        input  valid, func, position_key, bound_kind, search_depth,
               move_word, move_score, alpha_limit, beta_limit,
        output ready
    );

endinterface

[design/stt_rsp_if.sv]
// ---------------------------------------------------------------------------
// stt_rsp_if - response channel of the transposition table
// Valid/ready channel carrying one result transaction per request.
// ---------------------------------------------------------------------------
interface stt_rsp_if import stt_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [KIND_W-1:0]         result_kind;
    logic [MOVE_W-1:0]         found_move;
    logic signed [SCORE_W-1:0] found_score;
    logic [USED_W-1:0]         entries_used;
    logic [CNT_W-1:0]          hits_total;
    logic [CNT_W-1:0]          misses_total;

    modport source (
        output valid, hit, result_kind, found_move, found_score,
               entries_used, hits_total, misses_total,
        input  ready
    );

    modport sink (
        input  valid, hit, result_kind, found_move, found_score,
               entries_used, hits_total, misses_total,
        output ready
    );

endinterface

[design/stt_ram.sv]
// ---------------------------------------------------------------------------
// stt_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/stt_front.sv]
// ---------------------------------------------------------------------------
// stt_front - request front end
// Accepts a transaction, derives the slot index from the key and queues it.
// ---------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    stt_req_if.sink                          i_req,
    input  logic                             i_hold,
    input  logic                             i_full,
    output logic                             o_push,
    output t_cmd                             o_cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_idx
);

    localparam int  IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int  HALF_W  = KEY_W / 2;
    localparam int  ACC_W   = KEY_W + 2;
    localparam bit  IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

    // (2^64 - 1) / TABLE_ENTRIES, rounded down, split into 32-bit halves
    localparam logic [KEY_W-1:0]  RECIP    = {KEY_W{1'b1}} / KEY_W'(TABLE_ENTRIES);
    localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RECIP_HI = RECIP[KEY_W-1:HALF_W];
    localparam logic [IDX_W:0]    ENTRIES  = (IDX_W+1)'(TABLE_ENTRIES);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED, S_PUSH} t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [ACC_W-1:0]    r_acc;
    logic [KEY_W-1:0]    r_quo;
    logic [IDX_W:0]      r_rem;
    logic [1:0]          r_step;
    t_cmd                w_in;
    logic                w_accept;
    logic [HALF_W-1:0]   w_mul_a;
    logic [HALF_W-1:0]   w_mul_b;
    logic [KEY_W-1:0]    w_prod;
    logic [IDX_W:0]      n_rem;
    logic [IDX_W-1:0]    w_rem_idx;

    // request fields as one command
    always_comb begin
        w_in.func         = i_req.func;
        w_in.position_key = i_req.position_key;
        w_in.bound_kind   = i_req.bound_kind;
        w_in.search_depth = i_req.search_depth;
        w_in.move_word    = i_req.move_word;
        w_in.move_score   = i_req.move_score;
        w_in.alpha_limit  = i_req.alpha_limit;
        w_in.beta_limit   = i_req.beta_limit;
    end

    assign i_req.ready = (r_state == S_IDLE) && !i_hold;
    assign w_accept    = i_req.valid && i_req.ready;

    // quotient estimate: key times reciprocal, one 32x32 partial product per cycle
    assign w_mul_a = r_step[0] ? r_cmd.position_key[KEY_W-1:HALF_W]
                               : r_cmd.position_key[HALF_W-1:0];
    assign w_mul_b = r_step[1] ? RECIP_HI : RECIP_LO;
    assign w_prod  = w_mul_a * w_mul_b;

    // remainder from the low bits; the estimate is short by at most one
    assign n_rem     = r_cmd.position_key[IDX_W:0] - r_quo[IDX_W:0] * ENTRIES;
    assign w_rem_idx = (r_rem >= ENTRIES) ? IDX_W'(r_rem - ENTRIES) : r_rem[IDX_W-1:0];

    // control and capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= w_in;
                        r_step  <= '0;
                        r_state <= IS_POW2 ? S_PUSH : S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        2'd0: begin
                            r_acc <= ACC_W'(w_prod[KEY_W-1:HALF_W]);
                        end
                        2'd3: begin
                            r_quo   <= w_prod + KEY_W'(r_acc[ACC_W-1:HALF_W]);
                            r_state <= S_RED;
                        end
                        default: begin
                            r_acc <= r_acc + ACC_W'(w_prod);
                        end
                    endcase
                end
                S_RED: begin
                    r_rem   <= n_rem;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_cmd  = r_cmd;
    assign o_idx  = IS_POW2 ? r_cmd.position_key[IDX_W-1:0] : w_rem_idx;

`ifndef ASSERT_OFF
    // an accepted transaction closes the request side until it is queued
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("front accepted a second transaction while busy");
`endif

endmodule

[design/stt_fifo.sv]
// ---------------------------------------------------------------------------
// stt_fifo - command queue
// Short register queue decoupling the front end from the table update.
// ---------------------------------------------------------------------------
module stt_fifo import stt_pkg::*; #(
    parameter int IDX_W = $clog2(DEF_TABLE_ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_cmd             i_cmd,
    input  logic [IDX_W-1:0] i_idx,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_idx
);

    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int COUNT_W = $clog2(FIFO_DEPTH + 1);

    t_cmd               r_cmd [FIFO_DEPTH];
    logic [IDX_W-1:0]   r_idx [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [COUNT_W-1:0] r_count;

    assign o_full  = (r_count == COUNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_cmd[r_rptr];
    assign o_idx   = r_idx[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wptr] <= i_cmd;
            r_idx[r_wptr] <= i_idx;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/stt_back.sv]
// ---------------------------------------------------------------------------
// stt_back - table back end
// Clears the table after reset, then reads the slot of each queued command,
// updates or compares it and registers the result transaction.
// ---------------------------------------------------------------------------
module stt_back import stt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  t_cmd                             i_cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_idx,
    output logic                             o_pop,
    output logic                             o_clr_busy,
    stt_rsp_if.source                        o_rsp
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state                    r_state;
    logic [IDX_W-1:0]          r_clr_addr;
    t_cmd                      r_cmd;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_out_valid;
    logic                      r_hit;
    logic [KIND_W-1:0]         r_kind;
    logic [MOVE_W-1:0]         r_move;
    logic signed [SCORE_W-1:0] r_score;
    logic [USED_W-1:0]         r_used;
    logic [CNT_W-1:0]          r_hits;
    logic [CNT_W-1:0]          r_miss;

    logic                      w_clear;
    logic                      w_fire;
    logic                      w_store;
    logic                      w_hit;
    logic [SLOT_W-1:0]         w_rdata;
    t_slot                     w_slot;
    t_slot                     w_new;
    logic signed [SCORE_W-1:0] w_clamped;
    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr;
    logic [SLOT_W-1:0]         w_wdata;

    assign w_clear    = (r_state == S_CLEAR);
    assign o_clr_busy = w_clear;
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign w_store    = (r_cmd.func == FUNC_STORE);

    // slot table
    stt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (o_pop),
        .i_raddr (i_idx),
        .o_rdata (w_rdata)
    );

    assign w_slot = t_slot'(w_rdata);

    // replacement slot for a store
    always_comb begin
        w_new.key   = r_cmd.position_key;
        w_new.kind  = r_cmd.bound_kind;
        w_new.depth = r_cmd.search_depth;
        w_new.move  = r_cmd.move_word;
        w_new.score = r_cmd.move_score;
    end

    // clear sweep or store write
    assign w_we    = w_clear || (w_fire && w_store);
    assign w_waddr = w_clear ? r_clr_addr : r_idx;
    assign w_wdata = w_clear ? '0 : SLOT_W'(w_new);

    // probe compare and window clamp
    assign w_hit = (r_cmd.func == FUNC_PROBE)
                && (w_slot.key == r_cmd.position_key)
                && (w_slot.depth >= r_cmd.search_depth);

    always_comb begin
        w_clamped = w_slot.score;
        if (w_slot.kind == KIND_ALPHA && w_slot.score >= r_cmd.alpha_limit) begin
            w_clamped = r_cmd.alpha_limit;
        end else if (w_slot.kind == KIND_BETA && w_slot.score <= r_cmd.beta_limit) begin
            w_clamped = r_cmd.beta_limit;
        end
    end

    // sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_hits      <= '0;
            r_miss      <= '0;
        end else begin
            // a new result replaces the one taken in this cycle
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= i_idx;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_hit       <= w_hit;
                        r_kind      <= w_hit ? w_slot.kind : KIND_INVALID;
                        r_move      <= w_hit ? w_slot.move : '0;
                        r_score     <= w_hit ? w_clamped : '0;
                        if (w_store) begin
                            if (w_slot.kind == KIND_INVALID && r_used != USED_MAX) begin
                                r_used <= r_used + 1'b1;
                            end
                        end else if (w_hit) begin
                            r_hits <= r_hits + 1'b1;
                        end else begin
                            r_miss <= r_miss + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_hit;
    assign o_rsp.result_kind  = r_kind;
    assign o_rsp.found_move   = r_move;
    assign o_rsp.found_score  = r_score;
    assign o_rsp.entries_used = r_used;
    assign o_rsp.hits_total   = r_hits;
    assign o_rsp.misses_total = r_miss;

`ifndef ASSERT_OFF
    // no command leaves the queue during the clearing sweep
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |-> !o_pop)
        else $error("command popped during table clear");

    // a miss or a store reports empty hit fields
    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.hit) |->
        (o_rsp.result_kind == KIND_INVALID && o_rsp.found_move == '0
         && o_rsp.found_score == '0))
        else $error("non-hit result carries slot data");

    // the fill count never moves back
    a_used_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_clear |=> r_used >= $past(r_used))
        else $error("fill count decreased");

    // a slot update always completes before the next command is read
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_pop)
        else $error("second command read while one is in flight");
`endif

endmodule

[design/search_transposition_table.sv]
// ---------------------------------------------------------------------------
// search_transposition_table - direct-mapped transposition table
// Stores and probes search results in a table indexed by the position key.
//
// After reset all TABLE_ENTRIES slots (4096 by default) are swept clear
// with the request side held off; then each store or probe transaction
// returns exactly one result transaction, in order. The front end takes a
// request and forms the slot index directly from the low key bits when
// TABLE_ENTRIES is a power of two; otherwise the key remainder comes from a
// reciprocal multiply done as four 32x32 partial products and a reduction
// step. It takes no new request until the current one is queued. A two-entry
// queue hands commands to the back end, which reads the slot from the table
// RAM into its registered read data and then updates or compares it; it
// reads no further command until that transaction is finished. A finished
// result waits in an output register while the next transaction is already
// in progress. Hit and miss counts wrap at 2^32; the fill count saturates
// at 8191.
// ---------------------------------------------------------------------------
module search_transposition_table import stt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_req_if.sink    i_req,
    stt_rsp_if.source  o_rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;
    logic             w_clr_busy;
    t_cmd             w_push_cmd;
    t_cmd             w_pop_cmd;
    logic [IDX_W-1:0] w_push_idx;
    logic [IDX_W-1:0] w_pop_idx;

    // request front end
    stt_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_hold  (w_clr_busy),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd),
        .o_idx   (w_push_idx)
    );

    // command queue
    stt_fifo #(
        .IDX_W (IDX_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_idx   (w_push_idx),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_pop_cmd),
        .o_idx   (w_pop_idx)
    );

    // table back end
    stt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_cmd      (w_pop_cmd),
        .i_idx      (w_pop_idx),
        .o_pop      (w_pop),
        .o_clr_busy (w_clr_busy),
        .o_rsp      (o_rsp)
    );

endmodule
